// ----- rtl/core/dpar_pkg.sv -----
// ----------------------------------------------------------------------------
// dpar_pkg
// Shared types and constants for the data-processing ALU with register file.
// ----------------------------------------------------------------------------
`default_nettype none

package dpar_pkg;

  localparam int REG_COUNT = 16;
  localparam int RIDX_W    = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [3:0] OP_AND = 4'd0;
  localparam logic [3:0] OP_EOR = 4'd1;
  localparam logic [3:0] OP_SUB = 4'd2;
  localparam logic [3:0] OP_RSB = 4'd3;
  localparam logic [3:0] OP_ADD = 4'd4;
  localparam logic [3:0] OP_TST = 4'd8;
  localparam logic [3:0] OP_TEQ = 4'd9;
  localparam logic [3:0] OP_CMP = 4'd10;
  localparam logic [3:0] OP_ORR = 4'd12;
  localparam logic [3:0] OP_MOV = 4'd13;

  typedef enum logic [2:0] {
    FN_AND,
    FN_EOR,
    FN_ORR,
    FN_MOV,
    FN_SUB,
    FN_RSB,
    FN_ADD
  } alu_fn_t;

  typedef struct packed {
    logic [3:0]  operation;
    logic [3:0]  first_reg;
    logic [3:0]  dest_reg;
    logic        set_flags;
    logic [31:0] operand_two;
    logic        shifter_carry;
  } in_item_t;

  typedef struct packed {
    logic [31:0] result;
    logic        written;
    logic        flag_n;
    logic        flag_z;
    logic        flag_c;
    logic        unsupported;
  } out_item_t;

  typedef struct packed {
    alu_fn_t     fn;
    logic        supported;
    logic        writes;
    logic        arith;
    logic [3:0]  first_reg;
    logic [3:0]  dest_reg;
    logic        set_flags;
    logic [31:0] operand_two;
    logic        shifter_carry;
  } dec_item_t;

endpackage

`default_nettype wire

// ----- rtl/core/dpar_front.sv -----
// ----------------------------------------------------------------------------
// dpar_front
// Accepts input transactions and decodes the opcode into an execute entry.
// ----------------------------------------------------------------------------
`default_nettype none

module dpar_front
  import dpar_pkg::*;
(
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           push,
  output dec_item_t      push_data,
  input  wire logic      q_full
);

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_data               = '0;
    push_data.first_reg     = in_data.first_reg;
    push_data.dest_reg      = in_data.dest_reg;
    push_data.set_flags     = in_data.set_flags;
    push_data.operand_two   = in_data.operand_two;
    push_data.shifter_carry = in_data.shifter_carry;
    push_data.supported     = 1'b1;
    push_data.writes        = 1'b1;
    push_data.arith         = 1'b0;
    push_data.fn            = FN_AND;
    unique case (in_data.operation)
      OP_AND: push_data.fn = FN_AND;
      OP_EOR: push_data.fn = FN_EOR;
      OP_SUB: begin
        push_data.fn    = FN_SUB;
        push_data.arith = 1'b1;
      end
      OP_RSB: begin
        push_data.fn    = FN_RSB;
        push_data.arith = 1'b1;
      end
      OP_ADD: begin
        push_data.fn    = FN_ADD;
        push_data.arith = 1'b1;
      end
      OP_TST: begin
        push_data.fn     = FN_AND;
        push_data.writes = 1'b0;
      end
      OP_TEQ: begin
        push_data.fn     = FN_EOR;
        push_data.writes = 1'b0;
      end
      OP_CMP: begin
        push_data.fn     = FN_SUB;
        push_data.arith  = 1'b1;
        push_data.writes = 1'b0;
      end
      OP_ORR: push_data.fn = FN_ORR;
      OP_MOV: push_data.fn = FN_MOV;
      default: begin
        push_data.supported = 1'b0;
        push_data.writes    = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/dpar_fifo.sv -----
// ----------------------------------------------------------------------------
// dpar_fifo
// Short queue of decoded entries between the front and the execute stage.
// ----------------------------------------------------------------------------
`default_nettype none

module dpar_fifo
  import dpar_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire dec_item_t  push_data,
  output logic            full,
  output logic            q_valid,
  input  wire logic       pop,
  output dec_item_t       q_data
);

  localparam logic [FIFO_CNT_W-1:0] DEPTH_C = FIFO_CNT_W'(FIFO_DEPTH);
  localparam logic [FIFO_PTR_W-1:0] LAST_C  = FIFO_PTR_W'(FIFO_DEPTH - 1);

  dec_item_t               mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0]   count_r, count_nxt;
  logic                    do_push, do_pop;

  assign full    = (count_r == DEPTH_C);
  assign q_valid = (count_r != '0);
  assign q_data  = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_C) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_C) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/dpar_back.sv -----
// ----------------------------------------------------------------------------
// dpar_back
// Execute stage: register file read, ALU, write back, flags, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dpar_back
  import dpar_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_valid,
  input  wire dec_item_t  q_data,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_item_t       out_data
);

  localparam logic [4:0] REG_LIMIT = 5'(REG_COUNT);

  logic [31:0]  rf_r [REG_COUNT];
  logic [2:0]   flags_r, flags_nxt;
  logic         out_valid_r;
  out_item_t    out_data_r, out_data_nxt;

  logic [31:0]  op_a, alu_x, alu_y, logic_res, res;
  logic [32:0]  sum;
  logic         cin, carry, rd_ok, wr_en;

  assign pop       = q_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign op_a = ({1'b0, q_data.first_reg} < REG_LIMIT)
                ? rf_r[q_data.first_reg[RIDX_W-1:0]] : '0;

  always_comb begin
    alu_x = op_a;
    alu_y = q_data.operand_two;
    cin   = 1'b0;
    case (q_data.fn)
      FN_SUB: begin
        alu_y = ~q_data.operand_two;
        cin   = 1'b1;
      end
      FN_RSB: begin
        alu_x = q_data.operand_two;
        alu_y = ~op_a;
        cin   = 1'b1;
      end
      default: ;
    endcase
  end

  assign sum = {1'b0, alu_x} + {1'b0, alu_y} + 33'(cin);

  always_comb begin
    case (q_data.fn)
      FN_AND:  logic_res = op_a & q_data.operand_two;
      FN_EOR:  logic_res = op_a ^ q_data.operand_two;
      FN_ORR:  logic_res = op_a | q_data.operand_two;
      default: logic_res = q_data.operand_two;
    endcase
  end

  assign res   = q_data.arith ? sum[31:0] : logic_res;
  assign carry = q_data.arith ? sum[32] : q_data.shifter_carry;
  assign rd_ok = ({1'b0, q_data.dest_reg} < REG_LIMIT);
  assign wr_en = pop && q_data.writes && rd_ok;

  always_comb begin
    flags_nxt = flags_r;
    if (q_data.supported && q_data.set_flags) begin
      flags_nxt = {res[31], (res == '0), carry};
    end
    out_data_nxt.result      = q_data.supported ? res : '0;
    out_data_nxt.written     = q_data.writes && rd_ok;
    out_data_nxt.flag_n      = flags_nxt[2];
    out_data_nxt.flag_z      = flags_nxt[1];
    out_data_nxt.flag_c      = flags_nxt[0];
    out_data_nxt.unsupported = !q_data.supported;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      flags_r     <= '0;
      for (int i = 0; i < REG_COUNT; i++) begin
        rf_r[i] <= '0;
      end
    end else begin
      if (pop) begin
        out_valid_r <= 1'b1;
        flags_r     <= flags_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (wr_en) begin
        rf_r[q_data.dest_reg[RIDX_W-1:0]] <= res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/data_processing_alu_regfile_top.sv -----
// ----------------------------------------------------------------------------
// data_processing_alu_regfile_top
// Execute stage for decoded data-processing instructions with 16 registers.
//
// Input channel in_valid/in_ready/in_data carries one decoded instruction
// per transaction; output channel out_valid/out_ready/out_data returns one
// result per instruction, in order. The front decodes the opcode and pushes
// into a two-entry queue; the execute stage reads the source register, runs
// the single 33-bit adder or logic unit, writes the register file and the
// N/Z/C flags, and loads the output register in the same cycle.
// Each input is registered in the queue and then in the output register.
// Throughput: one instruction per cycle while out_ready is high, set by the single execute stage.
// When out_ready is low the output register holds, the queue fills and
// in_ready drops once two entries wait. Synchronous reset (rst_n low)
// clears the registers, flags, queue and output valid; in_ready is high
// in the first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module data_processing_alu_regfile_top
  import dpar_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  logic       push, q_full, q_valid, pop;
  dec_item_t  push_data, q_data;

  dpar_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  dpar_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .q_valid   (q_valid),
    .pop       (pop),
    .q_data    (q_data)
  );

  dpar_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- rtl/core/dpar_checker.sv -----
// ----------------------------------------------------------------------------
// dpar_checker
// Port-level assertions for the execute stage, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dpar_checker
  import dpar_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  a_unsup_no_effect: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.unsupported |-> !out_data.written && out_data.result == '0)
    else $error("unsupported transaction shows a result or a write");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output transaction changed");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready after reset");

  a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !(in_valid && in_ready) && $past(!(in_valid && in_ready)) &&
    $past(!out_valid) && $past(!in_valid, 2) |=> !out_valid)
    else $error("output transaction without a preceding input");

endmodule

bind data_processing_alu_regfile_top dpar_checker u_dpar_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
